[src/icy_pkg.sv]
// shared types and constants for the icy metadata stream splitter
`timescale 1ns / 1ps

package icy_pkg;

  // longest title kept is TITLE_MAX-1 characters
  localparam int TITLE_MAX = 64;
  localparam logic [7:0] TITLE_LIM = 8'(TITLE_MAX - 1);

  // result kinds
  localparam logic [1:0] KIND_AUDIO = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ABORT = 2'd3;

  // special bytes inside a metadata block
  localparam logic [7:0] CHAR_QUOTE = 8'h27;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;

  localparam logic [15:0] INTERVAL_RESET = 16'd8192;

  // queue between front and back, power of two so the pointers wrap by themselves
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    PH_AUDIO = 2'd0,
    PH_LEN   = 2'd1,
    PH_META  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    TP_BEFORE = 2'd0,
    TP_IN     = 2'd1,
    TP_DONE   = 2'd2
  } title_phase_t;

  // one or two results caused by one input byte
  typedef struct packed {
    logic       two;
    logic [1:0] kind0;
    logic [7:0] value0;
    logic [1:0] kind1;
    logic [7:0] value1;
  } icy_ent_t;

endpackage

[src/icy_front.sv]
// front end: takes stream bytes, tracks framing and title state, queues results
`timescale 1ns / 1ps

module icy_front import icy_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        q_full,
  output logic        q_push,
  output icy_ent_t    q_ent
);

  logic [15:0]  meta_interval;
  logic [15:0]  audio_left, audio_left_next;
  phase_t       phase, phase_next;
  logic [11:0]  meta_left, meta_left_next;
  title_phase_t title_phase, title_phase_next;
  logic         quote_held, quote_held_next;
  logic [7:0]   title_count, title_count_next;

  logic         accept;
  logic [15:0]  reload;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign reload   = (meta_interval == 16'd0) ? 16'd1 : meta_interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_interval <= INTERVAL_RESET;
    end else if (cfg_wr_en) begin
      meta_interval <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      audio_left  <= INTERVAL_RESET;
      phase       <= PH_AUDIO;
      meta_left   <= '0;
      title_phase <= TP_BEFORE;
      quote_held  <= 1'b0;
      title_count <= '0;
    end else if (accept) begin
      audio_left  <= audio_left_next;
      phase       <= phase_next;
      meta_left   <= meta_left_next;
      title_phase <= title_phase_next;
      quote_held  <= quote_held_next;
      title_count <= title_count_next;
    end
  end

  always_comb begin
    logic [15:0] a;
    logic [15:0] a_dec;
    logic [11:0] ml;
    logic        e_quote;
    logic        e_char;
    logic [7:0]  cnt1;

    audio_left_next  = audio_left;
    phase_next       = phase;
    meta_left_next   = meta_left;
    title_phase_next = title_phase;
    quote_held_next  = quote_held;
    title_count_next = title_count;
    q_push           = 1'b0;
    q_ent.two        = 1'b0;
    q_ent.kind0      = KIND_AUDIO;
    q_ent.value0     = data_byte;
    q_ent.kind1      = KIND_CHAR;
    q_ent.value1     = data_byte;
    a                = (audio_left == 16'd0) ? 16'd1 : audio_left;
    a_dec            = '0;
    ml               = meta_left - 12'd1;
    e_quote          = 1'b0;
    e_char           = 1'b0;
    cnt1             = title_count;

    case (phase)
      PH_LEN: begin
        if (data_byte == 8'd0) begin
          phase_next      = PH_AUDIO;
          audio_left_next = reload;
        end else begin
          meta_left_next   = {data_byte, 4'b0000};
          title_phase_next = TP_BEFORE;
          quote_held_next  = 1'b0;
          title_count_next = '0;
          phase_next       = PH_META;
        end
      end
      PH_META: begin
        if (meta_left == 12'd0) begin
          // block already spent: back to audio with a fresh interval
          a               = reload;
          a_dec           = a - 16'd1;
          q_push          = 1'b1;
          audio_left_next = a_dec;
          phase_next      = (a_dec == 16'd0) ? PH_LEN : PH_AUDIO;
        end else begin
          meta_left_next = ml;
          case (title_phase)
            TP_BEFORE: begin
              if (data_byte == CHAR_QUOTE) title_phase_next = TP_IN;
            end
            TP_IN: begin
              if (quote_held) begin
                if (data_byte == CHAR_SEMI) begin
                  quote_held_next  = 1'b0;
                  title_phase_next = TP_DONE;
                  q_push           = 1'b1;
                  q_ent.kind0      = KIND_DONE;
                  q_ent.value0     = 8'd0;
                end else begin
                  // held quote was a plain character after all
                  e_quote = (title_count < TITLE_LIM);
                  cnt1    = title_count + {7'd0, e_quote};
                  if (data_byte == CHAR_QUOTE) begin
                    quote_held_next = 1'b1;
                  end else begin
                    quote_held_next = 1'b0;
                    e_char          = (cnt1 < TITLE_LIM);
                  end
                end
              end else if (data_byte == CHAR_QUOTE) begin
                quote_held_next = 1'b1;
              end else begin
                e_char = (title_count < TITLE_LIM);
              end
              title_count_next = cnt1 + {7'd0, e_char};
              if (e_quote || e_char) begin
                q_push       = 1'b1;
                q_ent.two    = e_quote && e_char;
                q_ent.kind0  = KIND_CHAR;
                q_ent.value0 = e_quote ? CHAR_QUOTE : data_byte;
              end
            end
            default: begin
              // title done: rest of block ignored
            end
          endcase
          if (ml == 12'd0) begin
            // last byte of the block: an open title aborts
            if (title_phase_next == TP_IN) begin
              q_push       = 1'b1;
              q_ent.two    = 1'b0;
              q_ent.kind0  = KIND_ABORT;
              q_ent.value0 = 8'd0;
            end
            quote_held_next  = 1'b0;
            title_phase_next = TP_BEFORE;
            title_count_next = '0;
            phase_next       = PH_AUDIO;
            audio_left_next  = reload;
          end
        end
      end
      default: begin
        a_dec           = a - 16'd1;
        q_push          = 1'b1;
        audio_left_next = a_dec;
        phase_next      = (a_dec == 16'd0) ? PH_LEN : PH_AUDIO;
      end
    endcase

    if (!accept) q_push = 1'b0;
  end

endmodule

[src/icy_queue.sv]
// short result queue between front and back
`timescale 1ns / 1ps

module icy_queue import icy_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  icy_ent_t push_ent,
  output logic     full,
  input  logic     pop,
  output logic     nonempty,
  output icy_ent_t head
);

  icy_ent_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic                do_push;
  logic                do_pop;

  assign full     = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_ent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (do_push && !do_pop)      count <= count + (QPTR_W + 1)'(1);
      else if (do_pop && !do_push) count <= count - (QPTR_W + 1)'(1);
    end
  end

endmodule

[src/icy_back.sv]
// back end: plays queued entries out as one or two result beats
`timescale 1ns / 1ps

module icy_back import icy_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_nonempty,
  input  icy_ent_t   q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] value,
  output logic       last
);

  icy_ent_t ent;
  logic     ent_valid;
  logic     second;
  logic     take;
  logic     load;

  assign out_valid = ent_valid;
  assign kind      = second ? ent.kind1 : ent.kind0;
  assign value     = second ? ent.value1 : ent.value0;
  assign last      = second || !ent.two;
  assign take      = ent_valid && !out_stall;
  assign load      = !ent_valid || (take && last);
  assign q_pop     = load && q_nonempty;

  always_ff @(posedge clk) begin
    if (q_pop) ent <= q_head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
      second    <= 1'b0;
    end else if (load) begin
      ent_valid <= q_nonempty;
      second    <= 1'b0;
    end else if (take) begin
      second <= 1'b1;
    end
  end

endmodule

[src/icy_metadata_stream_splitter.sv]
// top level of the icy metadata stream splitter
`timescale 1ns / 1ps

// Splits the body of an ICY stream, one byte per beat, into audio bytes and
// the stream title. After every meta_interval audio bytes a length byte L
// follows, then 16*L metadata bytes (L of zero: no block). Audio bytes come
// out as kind 0; inside a block the text between the first quote and a quote
// followed by a semicolon comes out as kind 1 characters (at most 63), then a
// kind 2 marker; a block that ends with the title still open gives a kind 3
// marker instead. last marks the final result of each input byte, and bytes
// that cause no result (length byte, metadata outside the title) give none.
// An input beat can be taken every cycle while the queue is not full: the
// front end updates the framing counters and title state and writes the
// results of the byte into a four entry queue; the back end plays each
// entry out from an output register. A byte that yields two results (a
// held quote plus a character) holds the output for both, and the queue
// absorbs that, so input stalls only when such bytes come in a dense run
// or the output is stalled. The user writes meta_interval (reset 8192, zero
// acts as one) with cfg_wr_en only while the block is idle, which the block
// does not enforce; it takes effect at the next audio counter reload.

module icy_metadata_stream_splitter import icy_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  value,
  output logic        last
);

  // front to queue
  logic     q_push;
  icy_ent_t q_ent;
  logic     q_full;

  // queue to back
  logic     q_pop;
  logic     q_nonempty;
  icy_ent_t q_head;

  icy_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_ent       (q_ent)
  );

  icy_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_ent (q_ent),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  icy_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .value      (value),
    .last       (last)
  );

endmodule

[dv/icy_splitter_checker.sv]
// checker for the icy metadata stream splitter: predicts every result beat and compares it
`timescale 1ns / 1ps

module icy_splitter_checker import icy_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  value,
  input  logic        last,
  output int          mismatches,
  output int          outstanding,
  output int          results_seen
);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } split_beat_t;

  split_beat_t expected_q[$];
  split_beat_t byte_results[$];

  // predicted framing and title state
  logic [15:0]  interval_reg;
  logic [15:0]  audio_left;
  phase_t       phase;
  logic [11:0]  meta_left;
  title_phase_t title_phase;
  logic         quote_held;
  logic [7:0]   title_count;

  function automatic void emit(logic [1:0] k, logic [7:0] v);
    split_beat_t b;
    b.kind  = k;
    b.value = v;
    b.last  = 1'b0;
    byte_results.push_back(b);
  endfunction

  // characters past the title limit are dropped
  function automatic void emit_title_char(logic [7:0] ch);
    if (title_count < TITLE_LIM) begin
      title_count = title_count + 8'd1;
      emit(KIND_CHAR, ch);
    end
  endfunction

  function automatic void reload_audio();
    audio_left = (interval_reg == 16'd0) ? 16'd1 : interval_reg;
  endfunction

  function automatic void take_audio(logic [7:0] c);
    if (audio_left == 16'd0) audio_left = 16'd1;
    emit(KIND_AUDIO, c);
    audio_left = audio_left - 16'd1;
    if (audio_left == 16'd0) phase = PH_LEN;
  endfunction

  function automatic void predict_byte(logic [7:0] c);
    logic block_end;
    byte_results = {};
    case (phase)
      PH_LEN: begin
        if (c == 8'd0) begin
          phase = PH_AUDIO;
          reload_audio();
        end else begin
          meta_left   = {c, 4'h0};
          title_phase = TP_BEFORE;
          quote_held  = 1'b0;
          title_count = 8'd0;
          phase       = PH_META;
        end
      end
      PH_META: begin
        if (meta_left == 12'd0) begin
          phase = PH_AUDIO;
          reload_audio();
          take_audio(c);
        end else begin
          meta_left = meta_left - 12'd1;
          block_end = (meta_left == 12'd0);
          case (title_phase)
            TP_BEFORE: if (c == CHAR_QUOTE) title_phase = TP_IN;
            TP_IN: begin
              if (quote_held) begin
                if (c == CHAR_SEMI) begin
                  quote_held  = 1'b0;
                  title_phase = TP_DONE;
                  emit(KIND_DONE, 8'd0);
                end else begin
                  // held quote was part of the title after all
                  emit_title_char(CHAR_QUOTE);
                  quote_held = (c == CHAR_QUOTE);
                  if (c != CHAR_QUOTE) emit_title_char(c);
                end
              end else if (c == CHAR_QUOTE) begin
                quote_held = 1'b1;
              end else begin
                emit_title_char(c);
              end
            end
            default: ;
          endcase
          if (block_end) begin
            // open title at block end: only the abort marker survives
            if (title_phase == TP_IN) begin
              byte_results = {};
              emit(KIND_ABORT, 8'd0);
            end
            quote_held  = 1'b0;
            title_phase = TP_BEFORE;
            title_count = 8'd0;
            phase       = PH_AUDIO;
            reload_audio();
          end
        end
      end
      default: begin
        phase = PH_AUDIO;
        take_audio(c);
      end
    endcase
    foreach (byte_results[i]) begin
      byte_results[i].last = (i == byte_results.size() - 1);
      expected_q.push_back(byte_results[i]);
    end
  endfunction

  always @(posedge clk) begin
    split_beat_t want;
    if (rst) begin
      interval_reg = INTERVAL_RESET;
      audio_left   = INTERVAL_RESET;
      phase        = PH_AUDIO;
      meta_left    = 12'd0;
      title_phase  = TP_BEFORE;
      quote_held   = 1'b0;
      title_count  = 8'd0;
      mismatches   = 0;
      results_seen = 0;
      expected_q.delete();
    end else begin
      if (cfg_wr_en) interval_reg = cfg_wr_data;
      if (in_valid && !in_stall) predict_byte(data_byte);
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: kind %0d value %02h last %0b", kind, value, last);
        end else begin
          want = expected_q.pop_front();
          if (kind !== want.kind || value !== want.value || last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat %0d wrong: expected kind %0d value %02h last %0b, got %0d %02h %0b",
                       results_seen, want.kind, want.value, want.last, kind, value, last);
          end
        end
      end
    end
    outstanding = expected_q.size();
  end

endmodule

[dv/icy_metadata_stream_splitter_test.sv]
// testbench top for the icy metadata stream splitter: stimulus, idling and verdict
`timescale 1ns / 1ps

module icy_metadata_stream_splitter_test import icy_pkg::*; ();

  localparam int QUIET_LIMIT  = 5000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 8;     // settle margin after the last expected beat
  localparam int HOLD_CYCLES  = 300;   // long output hold-off, well past queue depth
  localparam int PHASE_BEATS  = 265;   // audio and text beats per random phase

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte   = 8'd0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  value;
  logic        last;

  int mismatches;
  int outstanding;
  int results_seen;

  // knobs for the current idling mix
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_pending   = 1'b0;

  int quiet_cycles  = 0;
  int beats_sent    = 0;
  int content_beats = 0;
  int blocks_sent   = 0;

  // framing as the stimulus sees it: the programmed interval only lands at
  // the next audio counter reload, so the current run length is kept apart
  logic [15:0] armed_interval = INTERVAL_RESET;
  int          run_len        = INTERVAL_RESET;
  logic [7:0]  meta_text[$];

  always #5 clk = ~clk;

  icy_metadata_stream_splitter dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .value      (value),
    .last       (last)
  );

  icy_splitter_checker splitter_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .value       (value),
    .last        (last),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .results_seen(results_seen)
  );

  // receiver: random stall per cycle, or one long hold-off when asked for
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // watchdog: the run is stuck if no beat moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // offer one beat, with random idle cycles ahead of it, and wait until taken
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // one frame: the current audio run, a length byte, then 16*len metadata
  // bytes taken from meta_text and padded with zeros or noise
  task automatic send_frame(int unsigned len, bit noisy_pad);
    int unsigned i;
    repeat (run_len) begin
      send_byte(8'($urandom_range(255)));
      content_beats++;
    end
    send_byte(8'(len));
    for (i = 0; i < 16 * len; i++) begin
      if (i < meta_text.size()) begin
        send_byte(meta_text[i]);
        content_beats++;
      end else begin
        send_byte(noisy_pad ? 8'($urandom_range(255)) : 8'h00);
      end
    end
    blocks_sent++;
    // empty block or block end both reload the audio counter
    run_len = (armed_interval == 16'd0) ? 1 : int'(armed_interval);
  endtask

  // stop offering and wait for every expected beat, plus the pipeline latency
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(logic [15:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    armed_interval = v;
  endtask

  function automatic void push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) meta_text.push_back(s[i]);
  endfunction

  function automatic void directed_text(string s);
    meta_text = {};
    push_text(s);
  endfunction

  // mostly printable title text, sometimes any byte at all
  function automatic logic [7:0] pick_title_char();
    logic [7:0] c;
    if ($urandom_range(99) < 80) begin
      c = 8'($urandom_range(32, 126));
      if (c == CHAR_QUOTE) c = CHAR_SEMI;
    end else begin
      c = 8'($urandom_range(255));
    end
    return c;
  endfunction

  // random metadata text: a well formed title most of the time, with stray
  // or doubled quotes, an unclosed title, a long title or plain noise mixed in
  function automatic void build_meta();
    int unsigned variant, tlen, i;
    meta_text = {};
    variant = $urandom_range(9);
    if (variant == 9) begin
      tlen = $urandom_range(1, 40);
      for (i = 0; i < tlen; i++) meta_text.push_back(8'($urandom_range(255)));
      return;
    end
    push_text("StreamTitle=");
    meta_text.push_back(CHAR_QUOTE);
    tlen = ($urandom_range(9) == 0) ? $urandom_range(55, 75) : $urandom_range(0, 20);
    for (i = 0; i < tlen; i++) begin
      if (variant < 3 && $urandom_range(7) == 0) begin
        meta_text.push_back(CHAR_QUOTE);
        if ($urandom_range(1) == 0) meta_text.push_back(CHAR_QUOTE);
      end else begin
        meta_text.push_back(pick_title_char());
      end
    end
    // one variant leaves the title open so the block end aborts it
    if (variant != 8) begin
      meta_text.push_back(CHAR_QUOTE);
      meta_text.push_back(CHAR_SEMI);
      if ($urandom_range(1) == 0) push_text("StreamUrl='x';");
    end
  endfunction

  initial begin
    int unsigned p, i, len, fit, r, start;
    bit hold_done;
    hold_done = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // the reset interval governs the first run; zero is armed meanwhile and
    // must act as one from the first reload on
    write_interval(16'd0);
    send_frame(0, 1'b0);

    // directed blocks, one audio byte between them
    directed_text("'AB''C';");             // held quote then quote, then a char
    send_frame(1, 1'b0);
    directed_text("x'abc");                // title left open: abort at block end
    send_frame(1, 1'b0);
    directed_text("...............'");     // opening quote is the last byte
    send_frame(1, 1'b0);
    directed_text("'abcdefghijklmn'");     // held quote on the last byte
    send_frame(1, 1'b0);
    directed_text("zz'abcdefghijk';");     // close lands on the last byte
    send_frame(1, 1'b0);
    directed_text("'a';'b';junk");         // text after the title is ignored
    send_frame(1, 1'b0);

    // overlong title: only the first 63 characters come out
    meta_text = {};
    meta_text.push_back(CHAR_QUOTE);
    for (i = 0; i < 70; i++) meta_text.push_back(8'h41 + 8'(i % 26));
    push_text("';");
    send_frame(5, 1'b0);

    // the held quote is the 63rd character, the one after it is dropped
    meta_text = {};
    meta_text.push_back(CHAR_QUOTE);
    for (i = 0; i < 62; i++) meta_text.push_back(8'h61 + 8'(i % 26));
    push_text("'X';");
    send_frame(5, 1'b0);

    // largest length byte
    directed_text("StreamTitle='big';");
    send_frame(255, 1'b0);

    // random part, one idling mix per phase
    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      write_interval((p == 0) ? 16'd1 : 16'($urandom_range(2, 40)));
      start = content_beats;
      while (content_beats - start < PHASE_BEATS) begin
        // one long receiver hold while the sender keeps pushing
        if (p == 2 && !hold_done && content_beats - start > 100) begin
          hold_pending = 1'b1;
          hold_done    = 1'b1;
        end
        build_meta();
        fit = (meta_text.size() + 15) / 16;
        r   = $urandom_range(199);
        if (r == 0)
          len = 255;
        else if (r < 12)
          len = 0;
        else if (r < 30 && fit > 1)
          len = $urandom_range(1, fit - 1);   // cut the text short
        else
          len = fit + $urandom_range(0, 1);
        send_frame(len, $urandom_range(3) == 0);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("summary: %0d input beats, %0d metadata blocks, %0d result beats, %0d mismatches",
             beats_sent, blocks_sent, results_seen, mismatches);
    $display("summary: intervals reset, 0, 1 and random; lengths 0 to 255; four stall mixes");
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
src/icy_pkg.sv
src/icy_front.sv
src/icy_queue.sv
src/icy_back.sv
src/icy_metadata_stream_splitter.sv
dv/icy_splitter_checker.sv
dv/icy_metadata_stream_splitter_test.sv
